/* hdl/sprx_pkg.sv */
package sprx_pkg;

  localparam int PacketMaxDefault   = 64;
  localparam int ChannelsMaxDefault = 16;

  localparam logic [7:0] SYNC_BYTE     = 8'hA4;
  localparam logic [7:0] STATUS_MASK   = 8'hFE;
  localparam logic [7:0] STATUS_OK_ALT = 8'h20;
  localparam logic [7:0] FLAG_BIT      = 8'h80;
  localparam logic [7:0] CRC_POLY_REFL = 8'h8C;

  typedef enum logic [2:0] {
    KIND_CHANNEL      = 3'd0,
    KIND_NO_CHANNELS  = 3'd1,
    KIND_CRC_ERROR    = 3'd2,
    KIND_STATUS_ERROR = 3'd3,
    KIND_OVERSIZE     = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_SINGLE   = 2'd1,
    EV_CHANNELS = 2'd2
  } event_t;

  typedef enum logic [1:0] {
    SEL_FLAG = 2'd0,
    SEL_HI   = 2'd1,
    SEL_LO   = 2'd2
  } rd_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_FLAG,
    S_RD_HI,
    S_RD_LO,
    S_LOAD,
    S_OUT
  } state_t;

  typedef struct packed {
    logic    take_byte;
    logic    start_chan;
    rd_sel_t rd_sel;
    logic    cap_flag;
    logic    cap_hi;
    logic    load_rec;
    logic    next_chan;
  } cmd_t;

  typedef struct packed {
    event_t ev;
    logic   out_last;
  } status_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_REFL;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* hdl/servo_packet_receiver_crc8_top.sv */
// Channel  Direction  Handshake             Payload
// in       input      in_valid, in_ready    rx_byte
// out      output     out_valid, out_ready  kind, channel_index, channel_value,
//                                           channel_updated, good_total, bad_total, last
//
// A byte that gives no result is taken and the controller stays idle. A byte that gives one
// error or no-channel result loads the output register in that cycle, and in_ready returns the
// cycle after that beat is taken. A byte that ends a good packet with n channels starts a loop
// over its records, held by output stalls: each record reads three bytes through the single
// read port of the packet store (S_RD_FLAG, S_RD_HI, S_RD_LO), then S_LOAD, before its beat.
// Synchronous reset clears the controller, counters and the saved status byte.
module servo_packet_receiver_crc8_top
  import sprx_pkg::*;
#(
  parameter int PACKET_MAX   = PacketMaxDefault,
  parameter int CHANNELS_MAX = ChannelsMaxDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [3:0]  channel_index,
  output logic [15:0] channel_value,
  output logic        channel_updated,
  output logic [31:0] good_total,
  output logic [31:0] bad_total,
  output logic        last
);

  cmd_t    cmd;
  status_t status;

  sprx_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .cmd      (cmd)
  );

  sprx_datapath #(
    .PACKET_MAX  (PACKET_MAX),
    .CHANNELS_MAX(CHANNELS_MAX)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .rx_byte        (rx_byte),
    .kind           (kind),
    .channel_index  (channel_index),
    .channel_value  (channel_value),
    .channel_updated(channel_updated),
    .good_total     (good_total),
    .bad_total      (bad_total),
    .last           (last)
  );

`ifndef SYNTH
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("Input taken while a result beat is pending.");

  a_more_records: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> !in_ready)
    else $error("Input reopened before the last record of a packet.");

  a_error_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind != KIND_CHANNEL) |->
      last && (channel_value == 16'd0) && !channel_updated && (channel_index == 4'd0))
    else $error("Non-record result carries channel fields.");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (status.ev == EV_SINGLE) |=>
      ((good_total != $past(good_total)) != (bad_total != $past(bad_total))))
    else $error("Single result did not move exactly one packet counter.");
`endif

endmodule

/* hdl/sprx_ram.sv */
module sprx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/sprx_ctrl.sv */
module sprx_ctrl
  import sprx_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (status.ev)
            EV_SINGLE:   state_next = S_OUT;
            EV_CHANNELS: state_next = S_RD_FLAG;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_RD_FLAG: state_next = S_RD_HI;
      S_RD_HI:   state_next = S_RD_LO;
      S_RD_LO:   state_next = S_LOAD;
      S_LOAD:    state_next = S_OUT;
      S_OUT: begin
        if (out_ready) begin
          state_next = status.out_last ? S_IDLE : S_RD_FLAG;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    out_valid      = 1'b0;
    cmd            = '0;
    cmd.rd_sel     = SEL_FLAG;
    unique case (state)
      S_IDLE: begin
        in_ready       = 1'b1;
        cmd.take_byte  = in_valid;
        cmd.start_chan = in_valid && (status.ev == EV_CHANNELS);
      end
      S_RD_FLAG: cmd.rd_sel = SEL_FLAG;
      S_RD_HI: begin
        cmd.rd_sel   = SEL_HI;
        cmd.cap_flag = 1'b1;
      end
      S_RD_LO: begin
        cmd.rd_sel = SEL_LO;
        cmd.cap_hi = 1'b1;
      end
      S_LOAD: cmd.load_rec = 1'b1;
      S_OUT: begin
        out_valid     = 1'b1;
        cmd.next_chan = out_ready && !status.out_last;
      end
      default: ;
    endcase
  end

endmodule

/* hdl/sprx_datapath.sv */
module sprx_datapath
  import sprx_pkg::*;
#(
  parameter int PACKET_MAX   = PacketMaxDefault,
  parameter int CHANNELS_MAX = ChannelsMaxDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output status_t     status,
  input  logic [7:0]  rx_byte,
  output logic [2:0]  kind,
  output logic [3:0]  channel_index,
  output logic [15:0] channel_value,
  output logic        channel_updated,
  output logic [31:0] good_total,
  output logic [31:0] bad_total,
  output logic        last
);

  localparam int AW = $clog2(PACKET_MAX);
  localparam int BW = $clog2(PACKET_MAX + 1);
  localparam int CW = $clog2(CHANNELS_MAX + 1);

  logic          hunting;
  logic [BW-1:0] byte_count;
  logic [7:0]    len;
  logic [7:0]    crc;
  logic [7:0]    status_byte;
  logic [31:0]   good_count;
  logic [31:0]   bad_count;
  logic [CW-1:0] chan_n;
  logic [CW-1:0] chan_k;
  logic          flag_clear;
  logic [7:0]    value_hi;
  kind_t         out_kind;
  logic [3:0]    out_index;
  logic [15:0]   out_value;
  logic          out_updated;
  logic          out_last;

  logic          pos_over;
  logic          at_len;
  logic          at_end;
  logic          oversize_len;
  logic [7:0]    crc_next;
  logic [7:0]    status_now;
  logic          status_ok;
  logic [5:0]    n_raw;
  logic [CW-1:0] n_clamped;
  logic          err;
  logic          good;
  kind_t         err_kind;
  event_t        ev;
  logic          last_chan;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW:0]   raddr_wide;
  logic [7:0]    rd_data;

  assign pos_over     = byte_count >= BW'(PACKET_MAX);
  assign at_len       = byte_count == BW'(1);
  assign at_end       = 9'(byte_count) == (9'(len) + 9'd2);
  assign oversize_len = (9'(rx_byte) + 9'd3) > 9'(PACKET_MAX);
  assign crc_next     = crc8_step(crc, rx_byte);
  assign status_now   = (byte_count == BW'(3)) ? rx_byte : status_byte;
  assign status_ok    = ((status_now & STATUS_MASK) == 8'h00) ||
                        ((status_now & STATUS_MASK) == STATUS_OK_ALT);
  assign n_raw        = (len >= 8'd4) ? 6'((len - 8'd4) >> 2) : 6'd0;
  assign n_clamped    = (8'(n_raw) > 8'(CHANNELS_MAX)) ? CW'(CHANNELS_MAX) : CW'(n_raw);
  assign last_chan    = ((CW + 1)'(chan_k) + (CW + 1)'(1)) == (CW + 1)'(chan_n);

  always_comb begin
    err      = 1'b0;
    good     = 1'b0;
    err_kind = KIND_OVERSIZE;
    ev       = EV_NONE;
    if (!hunting) begin
      if (pos_over) begin
        err = 1'b1;
      end else if (at_len) begin
        err = oversize_len;
      end else if (at_end) begin
        if (crc != rx_byte) begin
          err      = 1'b1;
          err_kind = KIND_CRC_ERROR;
        end else if (!status_ok) begin
          err      = 1'b1;
          err_kind = KIND_STATUS_ERROR;
        end else begin
          good = 1'b1;
        end
      end
    end
    if (err || (good && (n_clamped == '0))) begin
      ev = EV_SINGLE;
    end else if (good) begin
      ev = EV_CHANNELS;
    end
  end

  assign mem_we     = cmd.take_byte && (hunting ? (rx_byte == SYNC_BYTE) : !pos_over);
  assign mem_waddr  = hunting ? '0 : byte_count[AW-1:0];
  assign raddr_wide = (AW + 1)'({chan_k, 2'b00}) + (AW + 1)'(5) + (AW + 1)'(cmd.rd_sel);

  sprx_ram #(
    .WIDTH(8),
    .DEPTH(PACKET_MAX)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(rx_byte),
    .raddr(raddr_wide[AW-1:0]),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hunting     <= 1'b1;
      byte_count  <= '0;
      crc         <= '0;
      status_byte <= '0;
      good_count  <= '0;
      bad_count   <= '0;
      chan_k      <= '0;
    end else begin
      if (cmd.take_byte) begin
        if (hunting) begin
          if (rx_byte == SYNC_BYTE) begin
            crc        <= crc8_step(8'h00, rx_byte);
            byte_count <= BW'(1);
            hunting    <= 1'b0;
          end
        end else if (!pos_over) begin
          byte_count <= byte_count + BW'(1);
          if (!at_end) begin
            crc <= crc_next;
          end
          if (byte_count == BW'(3)) begin
            status_byte <= rx_byte;
          end
        end
        if (err) begin
          bad_count <= bad_count + 32'd1;
          hunting   <= 1'b1;
        end
        if (good) begin
          good_count <= good_count + 32'd1;
          hunting    <= 1'b1;
        end
      end
      if (cmd.start_chan) begin
        chan_k <= '0;
      end else if (cmd.next_chan) begin
        chan_k <= chan_k + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_byte && !hunting && !pos_over && at_len) begin
      len <= rx_byte;
    end
    if (cmd.take_byte && good) begin
      chan_n <= n_clamped;
    end
    if (cmd.cap_flag) begin
      flag_clear <= (rd_data & FLAG_BIT) == 8'h00;
    end
    if (cmd.cap_hi) begin
      value_hi <= rd_data;
    end
    if (cmd.take_byte && (ev == EV_SINGLE)) begin
      out_kind    <= err ? err_kind : KIND_NO_CHANNELS;
      out_index   <= '0;
      out_value   <= '0;
      out_updated <= 1'b0;
      out_last    <= 1'b1;
    end else if (cmd.load_rec) begin
      out_kind    <= KIND_CHANNEL;
      out_index   <= 4'(chan_k);
      out_value   <= {value_hi, rd_data};
      out_updated <= flag_clear;
      out_last    <= last_chan;
    end
  end

  assign status.ev       = ev;
  assign status.out_last = out_last;

  assign kind            = out_kind;
  assign channel_index   = out_index;
  assign channel_value   = out_value;
  assign channel_updated = out_updated;
  assign good_total      = good_count;
  assign bad_total       = bad_count;
  assign last            = out_last;

endmodule
